// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the list design files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock outside reset
`define ASSERT_CHECK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CHECK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== design/ili_pkg.sv =====
// ----------------------------------------------------------------------------
// ili_pkg
// shared types and codes for the indexed list
// ----------------------------------------------------------------------------
package ili_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_WORD_WIDTH = 32;

    localparam int FUNC_W   = 3;
    localparam int POS_W    = 16;
    localparam int IO_W     = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FN_APPEND    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DEL_LAST  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ      = 3'd4;
    localparam logic [FUNC_W-1:0] FN_READ_LAST = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_TAKE_PREV,
        CELL_TAKE_NEXT
    } cell_op_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  position;
        logic [IO_W-1:0]   word_in;
    } req_t;

    typedef struct packed {
        logic [IO_W-1:0]     word_out;
        logic [COUNT_W-1:0]  entry_count;
        logic [STATUS_W-1:0] status;
    } rsp_t;

endpackage

// ===== design/indexed_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// ordered list of data words kept in a chain of shifting cells
// ----------------------------------------------------------------------------
// req channel: valid/ready, one request word (func, position, word_in) per
// handshake. rsp channel: valid/ready, one response word (word_out,
// entry_count, status) per request, in request order.
// one request is worked on at a time; req_ready is high only while idle.
// a request passes S_EXEC and S_DONE for list edits and failed requests,
// S_EXEC, S_READ and S_DONE for reads, and S_EXEC, S_DIV, S_READ and S_DONE
// for a read whose position is at or beyond the count, where the bit-serial
// remainder unit works one bit of position per cycle. the next request is
// taken only after the response has gone valid, so a new request is not
// started before the last one is through. an insert or delete moves every
// cell at or above the position in the same cycle.
// the response sits in an output register; while rsp_ready is low the
// finished result waits there and the block already takes and works the
// next request, holding its result until the register frees up.
// reset clears the entry count and rsp_valid and puts the block in idle; cell
// contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_list_insert_delete #(
    parameter int CAPACITY   = ili_pkg::DEF_CAPACITY,
    parameter int WORD_WIDTH = ili_pkg::DEF_WORD_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ili_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ili_pkg::rsp_t rsp
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int EXT_W  = (WORD_WIDTH > ili_pkg::IO_W) ? WORD_WIDTH : ili_pkg::IO_W;
    localparam int CEXT_W = (CNT_W > ili_pkg::COUNT_W) ? CNT_W : ili_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_READ,
        S_DONE
    } state_t;

    state_t                     state_reg;
    ili_pkg::req_t              req_reg;
    logic [CNT_W-1:0]           occ_reg;
    logic [IDX_W-1:0]           rd_idx_reg;
    logic [WORD_WIDTH-1:0]      res_word_reg;
    logic [ili_pkg::STATUS_W-1:0] res_status_reg;
    logic                       rsp_valid_reg;
    ili_pkg::rsp_t              rsp_reg;

    // decode of the latched request against the current count
    logic                       ins_en;
    logic                       del_en;
    logic [IDX_W-1:0]           op_pos;
    logic [CNT_W-1:0]           occ_next;
    logic [ili_pkg::STATUS_W-1:0] status_next;
    logic                       rd_en;
    logic                       wrap_en;
    logic [IDX_W-1:0]           rd_idx_next;

    logic [ili_pkg::POS_W-1:0]  occ_wide;
    logic                       full;
    logic                       empty;

    logic [EXT_W-1:0]           win_ext;
    logic [WORD_WIDTH-1:0]      load_word;
    logic [EXT_W-1:0]           rd_ext;
    logic [CEXT_W-1:0]          cnt_ext;

    logic [WORD_WIDTH-1:0]      cell_word [CAPACITY];
    ili_pkg::cell_op_t          cell_op   [CAPACITY];

    logic                       div_start;
    logic                       div_done;
    logic [IDX_W-1:0]           div_rem;

    logic                       out_free;

    assign occ_wide = ili_pkg::POS_W'(occ_reg);
    assign full     = (occ_reg >= CNT_W'(CAPACITY));
    assign empty    = (occ_reg == '0);

    always_comb
    begin
        ins_en      = 1'b0;
        del_en      = 1'b0;
        op_pos      = req_reg.position[IDX_W-1:0];
        occ_next    = occ_reg;
        status_next = ili_pkg::ST_OK;
        rd_en       = 1'b0;
        wrap_en     = 1'b0;
        rd_idx_next = req_reg.position[IDX_W-1:0];
        unique case (req_reg.func)
            ili_pkg::FN_APPEND:
            begin
                if (full)
                    status_next = ili_pkg::ST_FULL;
                else
                begin
                    ins_en   = 1'b1;
                    op_pos   = occ_reg[IDX_W-1:0];
                    occ_next = occ_reg + 1'b1;
                end
            end
            ili_pkg::FN_INSERT:
            begin
                if (req_reg.position > occ_wide)
                    status_next = ili_pkg::ST_BADIDX;
                else if (full)
                    status_next = ili_pkg::ST_FULL;
                else
                begin
                    ins_en   = 1'b1;
                    occ_next = occ_reg + 1'b1;
                end
            end
            ili_pkg::FN_DELETE:
            begin
                if (empty)
                    status_next = ili_pkg::ST_EMPTY;
                else if (req_reg.position >= occ_wide)
                    status_next = ili_pkg::ST_BADIDX;
                else
                begin
                    del_en   = 1'b1;
                    occ_next = occ_reg - 1'b1;
                end
            end
            ili_pkg::FN_DEL_LAST:
            begin
                if (empty)
                    status_next = ili_pkg::ST_EMPTY;
                else
                    occ_next = occ_reg - 1'b1;
            end
            ili_pkg::FN_READ:
            begin
                if (empty)
                    status_next = ili_pkg::ST_EMPTY;
                else
                begin
                    rd_en   = 1'b1;
                    wrap_en = (req_reg.position >= occ_wide);
                end
            end
            ili_pkg::FN_READ_LAST:
            begin
                if (empty)
                    status_next = ili_pkg::ST_EMPTY;
                else
                begin
                    rd_en       = 1'b1;
                    rd_idx_next = IDX_W'(occ_reg - 1'b1);
                end
            end
            default:
            begin
                status_next = ili_pkg::ST_OK;
            end
        endcase
    end

    assign win_ext   = EXT_W'(req_reg.word_in);
    assign load_word = win_ext[WORD_WIDTH-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [WORD_WIDTH-1:0] prev_w;
            logic [WORD_WIDTH-1:0] next_w;

            if (gi == 0)
            begin : g_first
                assign prev_w = cell_word[gi];
            end
            else
            begin : g_prev
                assign prev_w = cell_word[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_w = cell_word[gi];
            end
            else
            begin : g_next
                assign next_w = cell_word[gi+1];
            end

            always_comb
            begin
                cell_op[gi] = ili_pkg::CELL_HOLD;
                if (state_reg == S_EXEC)
                begin
                    if (ins_en && (IDX_W'(gi) == op_pos))
                        cell_op[gi] = ili_pkg::CELL_LOAD;
                    else if (ins_en && (IDX_W'(gi) > op_pos))
                        cell_op[gi] = ili_pkg::CELL_TAKE_PREV;
                    else if (del_en && (IDX_W'(gi) >= op_pos))
                        cell_op[gi] = ili_pkg::CELL_TAKE_NEXT;
                end
            end

            ili_cell #(
                .WORD_WIDTH (WORD_WIDTH)
            ) u_cell (
                .clk       (clk),
                .op        (cell_op[gi]),
                .load_word (load_word),
                .prev_word (prev_w),
                .next_word (next_w),
                .word      (cell_word[gi])
            );
        end
    endgenerate

    assign div_start = (state_reg == S_EXEC) && rd_en && wrap_en;

    ili_rem #(
        .CAPACITY (CAPACITY)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (req_reg.position),
        .divisor   (occ_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign rd_ext   = EXT_W'(res_word_reg);
    assign cnt_ext  = CEXT_W'(occ_reg);
    assign out_free = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_DONE) && out_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    occ_reg <= occ_next;
                    if (rd_en && wrap_en)
                        state_reg <= S_DIV;
                    else if (rd_en)
                        state_reg <= S_READ;
                    else
                        state_reg <= S_DONE;
                end
                S_DIV:
                begin
                    if (div_done)
                        state_reg <= S_READ;
                end
                S_READ:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            req_reg <= req;
        if (state_reg == S_EXEC)
        begin
            res_status_reg <= status_next;
            res_word_reg   <= '0;
            rd_idx_reg     <= rd_idx_next;
        end
        if ((state_reg == S_DIV) && div_done)
            rd_idx_reg <= div_rem;
        if (state_reg == S_READ)
            res_word_reg <= cell_word[rd_idx_reg];
        if ((state_reg == S_DONE) && out_free)
        begin
            rsp_reg.word_out    <= rd_ext[ili_pkg::IO_W-1:0];
            rsp_reg.entry_count <= cnt_ext[ili_pkg::COUNT_W-1:0];
            rsp_reg.status      <= res_status_reg;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_CHECK(a_occ_max, clk, rst_n, occ_reg <= CNT_W'(CAPACITY))
    `ASSERT_CHECK(a_occ_hold, clk, rst_n, (state_reg != S_EXEC) |=> $stable(occ_reg))
    `ASSERT_CHECK(a_accept_exec, clk, rst_n, (req_valid && req_ready) |=> (state_reg == S_EXEC))
    `ASSERT_CHECK(a_rsp_from_done, clk, rst_n, $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))

endmodule

// ===== design/ili_cell.sv =====
// ----------------------------------------------------------------------------
// ili_cell
// one list slot: holds a word, loads a new one or takes a neighbor's
// ----------------------------------------------------------------------------
module ili_cell #(
    parameter int WORD_WIDTH = ili_pkg::DEF_WORD_WIDTH
) (
    input  logic                  clk,
    input  ili_pkg::cell_op_t     op,
    input  logic [WORD_WIDTH-1:0] load_word,
    input  logic [WORD_WIDTH-1:0] prev_word,
    input  logic [WORD_WIDTH-1:0] next_word,
    output logic [WORD_WIDTH-1:0] word
);

    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;

    always_comb
    begin
        unique case (op)
            ili_pkg::CELL_LOAD:      word_next = load_word;
            ili_pkg::CELL_TAKE_PREV: word_next = prev_word;
            ili_pkg::CELL_TAKE_NEXT: word_next = next_word;
            default:                 word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== design/ili_rem.sv =====
// ----------------------------------------------------------------------------
// ili_rem
// bit-serial remainder of a list index by the entry count
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ili_rem #(
    parameter int CAPACITY = ili_pkg::DEF_CAPACITY
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ili_pkg::POS_W-1:0]      dividend,
    input  logic [$clog2(CAPACITY+1)-1:0]  divisor,
    output logic                           done,
    output logic [$clog2(CAPACITY)-1:0]    remainder
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int STEP_W = $clog2(ili_pkg::POS_W);

    logic [ili_pkg::POS_W-1:0] dvd_reg;
    logic [CNT_W-1:0]          rem_reg;
    logic [STEP_W-1:0]         step_reg;
    logic                      run_reg;
    logic                      done_reg;

    logic [CNT_W:0] trial;
    logic [CNT_W:0] diff;
    logic [CNT_W-1:0] rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[ili_pkg::POS_W-1]};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor})
            rem_next = diff[CNT_W-1:0];
        else
            rem_next = trial[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(ili_pkg::POS_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[ili_pkg::POS_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[IDX_W-1:0];

    `ASSERT_NEVER(a_no_restart, clk, rst_n, start && run_reg)
    `ASSERT_CHECK(a_rem_below, clk, rst_n, done_reg |-> (rem_reg < divisor))
    `ASSERT_CHECK(a_run_ends, clk, rst_n, (run_reg && !start) |=> (run_reg || done_reg))

endmodule
